>>> rtl/hht_pkg.sv
// Shared types and constants for the quad handle hit test.
package hht_pkg;

    localparam int CoordW = 16;
    localparam int DiffW  = 17;
    localparam int ProdW  = 34;
    localparam int DistW  = 34;
    localparam int DotW   = 35;
    localparam int R2W    = 30;
    localparam int QuotW  = 31;
    localparam int NumC   = 4;
    localparam int CfgIdxW = 3;

    localparam logic [CfgIdxW-1:0] REG_CORNER_0 = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_CORNER_1 = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_CORNER_2 = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_CORNER_3 = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_RADIUS   = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_SURFACE  = 3'd5;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_VERTEX = 2'd1,
        KIND_EDGE   = 2'd2,
        KIND_BODY   = 2'd3
    } kind_t;

    typedef struct packed {
        logic             interior;
        logic [DistW-1:0] fixed_dist;
        logic [DistW-1:0] abs_cross;
        logic [DistW-1:0] len2;
    } edge_job_t;

    typedef struct packed {
        logic                  vertex_hit;
        logic [1:0]            vertex_idx;
        logic                  body_hit;
        edge_job_t [NumC-1:0]  edges;
    } job_t;

endpackage

>>> rtl/hht_front.sv
// Front pipeline: distances, projections and cross products; vertex and body decisions.
module hht_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [hht_pkg::CoordW-1:0]     in_x,
    input  logic signed [hht_pkg::CoordW-1:0]     in_y,
    input  logic [hht_pkg::NumC-1:0][31:0]        corners,
    input  logic [hht_pkg::R2W-1:0]               r2,
    input  logic                                  q_full,
    output logic                                  q_push,
    output hht_pkg::job_t                         q_job
);

    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    logic signed [hht_pkg::DiffW-1:0] ex_reg [hht_pkg::NumC];
    logic signed [hht_pkg::DiffW-1:0] ey_reg [hht_pkg::NumC];
    logic signed [hht_pkg::DiffW-1:0] dx_reg [hht_pkg::NumC];
    logic signed [hht_pkg::DiffW-1:0] dy_reg [hht_pkg::NumC];
    logic signed [hht_pkg::DiffW-1:0] ex_next [hht_pkg::NumC];
    logic signed [hht_pkg::DiffW-1:0] ey_next [hht_pkg::NumC];
    logic signed [hht_pkg::DiffW-1:0] dx_next [hht_pkg::NumC];
    logic signed [hht_pkg::DiffW-1:0] dy_next [hht_pkg::NumC];

    logic signed [hht_pkg::ProdW-1:0] exx_reg [hht_pkg::NumC];
    logic signed [hht_pkg::ProdW-1:0] eyy_reg [hht_pkg::NumC];
    logic signed [hht_pkg::ProdW-1:0] dxx_reg [hht_pkg::NumC];
    logic signed [hht_pkg::ProdW-1:0] dyy_reg [hht_pkg::NumC];
    logic signed [hht_pkg::ProdW-1:0] exdx_reg [hht_pkg::NumC];
    logic signed [hht_pkg::ProdW-1:0] eydy_reg [hht_pkg::NumC];
    logic signed [hht_pkg::ProdW-1:0] exdy_reg [hht_pkg::NumC];
    logic signed [hht_pkg::ProdW-1:0] eydx_reg [hht_pkg::NumC];

    logic [hht_pkg::DistW-1:0]        vd_reg [hht_pkg::NumC];
    logic [hht_pkg::DistW-1:0]        len2_reg [hht_pkg::NumC];
    logic signed [hht_pkg::DotW-1:0]  dot_reg [hht_pkg::NumC];
    logic signed [hht_pkg::DotW-1:0]  cr_reg [hht_pkg::NumC];

    hht_pkg::job_t job_reg, job_next;

    assign adv      = !v4_reg || !q_full;
    assign in_ready = adv;
    assign q_push   = v4_reg && !q_full;
    assign q_job    = job_reg;

    always_comb begin
        logic signed [hht_pkg::DiffW-1:0] px, py, cx, cy, nx, ny;
        px = {in_x[hht_pkg::CoordW-1], in_x};
        py = {in_y[hht_pkg::CoordW-1], in_y};
        for (int i = 0; i < hht_pkg::NumC; i++) begin
            cx = {corners[i][15], corners[i][15:0]};
            cy = {corners[i][31], corners[i][31:16]};
            nx = {corners[(i + 1) % hht_pkg::NumC][15], corners[(i + 1) % hht_pkg::NumC][15:0]};
            ny = {corners[(i + 1) % hht_pkg::NumC][31], corners[(i + 1) % hht_pkg::NumC][31:16]};
            ex_next[i] = px - cx;
            ey_next[i] = py - cy;
            dx_next[i] = nx - cx;
            dy_next[i] = ny - cy;
        end
    end

    always_comb begin
        logic [hht_pkg::DistW-1:0] best;
        logic                      any_neg, any_pos, start_c, end_c;
        logic [hht_pkg::DotW-1:0]  neg_cr;
        job_next = '0;
        best = hht_pkg::DistW'(r2);
        any_neg = 1'b0;
        any_pos = 1'b0;
        for (int i = 0; i < hht_pkg::NumC; i++) begin
            if (vd_reg[i] < best) begin
                best = vd_reg[i];
                job_next.vertex_hit = 1'b1;
                job_next.vertex_idx = 2'(i);
            end
        end
        for (int i = 0; i < hht_pkg::NumC; i++) begin
            if (cr_reg[i] < 0) any_neg = 1'b1;
            if (cr_reg[i] > 0) any_pos = 1'b1;
            start_c = (len2_reg[i] == '0) || (dot_reg[i] <= 0);
            end_c   = !start_c && (dot_reg[i] >= $signed({1'b0, len2_reg[i]}));
            job_next.edges[i].interior = !start_c && !end_c;
            job_next.edges[i].fixed_dist = start_c ? vd_reg[i]
                                                   : vd_reg[(i + 1) % hht_pkg::NumC];
            neg_cr = -cr_reg[i];
            job_next.edges[i].abs_cross = (cr_reg[i] < 0) ? neg_cr[hht_pkg::DistW-1:0]
                                                           : cr_reg[i][hht_pkg::DistW-1:0];
            job_next.edges[i].len2 = len2_reg[i];
        end
        job_next.body_hit = !any_neg || !any_pos;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < hht_pkg::NumC; i++) begin
                ex_reg[i]   <= ex_next[i];
                ey_reg[i]   <= ey_next[i];
                dx_reg[i]   <= dx_next[i];
                dy_reg[i]   <= dy_next[i];
                exx_reg[i]  <= ex_reg[i] * ex_reg[i];
                eyy_reg[i]  <= ey_reg[i] * ey_reg[i];
                dxx_reg[i]  <= dx_reg[i] * dx_reg[i];
                dyy_reg[i]  <= dy_reg[i] * dy_reg[i];
                exdx_reg[i] <= ex_reg[i] * dx_reg[i];
                eydy_reg[i] <= ey_reg[i] * dy_reg[i];
                exdy_reg[i] <= ex_reg[i] * dy_reg[i];
                eydx_reg[i] <= ey_reg[i] * dx_reg[i];
                vd_reg[i]   <= hht_pkg::DistW'(exx_reg[i]) + hht_pkg::DistW'(eyy_reg[i]);
                len2_reg[i] <= hht_pkg::DistW'(dxx_reg[i]) + hht_pkg::DistW'(dyy_reg[i]);
                dot_reg[i]  <= hht_pkg::DotW'(exdx_reg[i]) + hht_pkg::DotW'(eydy_reg[i]);
                cr_reg[i]   <= hht_pkg::DotW'(exdy_reg[i]) - hht_pkg::DotW'(eydx_reg[i]);
            end
            job_reg <= job_next;
        end
    end

endmodule

>>> rtl/hht_fifo.sv
// Small queue of classified jobs between the front and back pipelines.
module hht_fifo #(
    parameter int DEPTH = 4,
    parameter int W     = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         empty
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    logic [W-1:0]    mem [DEPTH];
    logic [PtrW-1:0] wptr_reg, rptr_reg;
    logic [CntW-1:0] cnt_reg;

    assign full  = (cnt_reg == CntW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign dout  = mem[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) begin
                wptr_reg <= (wptr_reg == PtrW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == PtrW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_reg] <= din;
        end
    end

endmodule

>>> rtl/hht_back.sv
// Back pipeline: squared cross, restoring division per edge, final handle pick.
module hht_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  hht_pkg::job_t                 in_job,
    input  logic [hht_pkg::R2W-1:0]       r2,
    input  logic [15:0]                   surface,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_hit,
    output hht_pkg::kind_t                out_kind,
    output logic [1:0]                    out_index,
    output logic [15:0]                   out_surface
);

    localparam int QB = hht_pkg::QuotW;
    localparam int NC = hht_pkg::NumC;
    localparam int DW = hht_pkg::DistW;

    logic adv;
    logic out_valid_reg;

    logic          b1_valid_reg;
    hht_pkg::job_t b1_job_reg;
    logic [33:0]   hh_reg [NC];
    logic [33:0]   hl_reg [NC];
    logic [33:0]   ll_reg [NC];

    logic          dv_reg  [0:QB];
    hht_pkg::job_t job_reg [0:QB];
    logic [DW-1:0] rem_reg [0:QB][NC];
    logic [QB-1:0] low_reg [0:QB][NC];
    logic [QB-1:0] q_reg   [0:QB][NC];
    logic          big_reg [0:QB][NC];

    logic           hit_reg;
    hht_pkg::kind_t kind_reg, kind_next;
    logic [1:0]     index_reg, index_next;
    logic [15:0]    surf_reg;

    assign adv         = !out_valid_reg || out_ready;
    assign in_ready    = adv;
    assign out_valid   = out_valid_reg;
    assign out_hit     = hit_reg;
    assign out_kind    = kind_reg;
    assign out_index   = index_reg;
    assign out_surface = surf_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            b1_job_reg <= in_job;
            for (int i = 0; i < NC; i++) begin
                hh_reg[i] <= in_job.edges[i].abs_cross[33:17] * in_job.edges[i].abs_cross[33:17];
                hl_reg[i] <= in_job.edges[i].abs_cross[33:17] * in_job.edges[i].abs_cross[16:0];
                ll_reg[i] <= in_job.edges[i].abs_cross[16:0] * in_job.edges[i].abs_cross[16:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        logic [67:0] a;
        if (adv) begin
            job_reg[0] <= b1_job_reg;
            for (int i = 0; i < NC; i++) begin
                a = {hh_reg[i], 34'd0} + {16'd0, hl_reg[i], 18'd0} + {34'd0, ll_reg[i]};
                big_reg[0][i] <= a[67:QB] >= {3'd0, b1_job_reg.edges[i].len2};
                rem_reg[0][i] <= a[QB+DW-1:QB];
                low_reg[0][i] <= a[QB-1:0];
                q_reg[0][i]   <= '0;
            end
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_div
        always_ff @(posedge aclk) begin
            logic [DW:0] t;
            logic        ge;
            if (adv) begin
                job_reg[k] <= job_reg[k-1];
                for (int i = 0; i < NC; i++) begin
                    t  = {rem_reg[k-1][i], low_reg[k-1][i][QB-1]};
                    ge = t >= {1'b0, job_reg[k-1].edges[i].len2};
                    rem_reg[k][i] <= ge ? DW'(t - {1'b0, job_reg[k-1].edges[i].len2})
                                        : t[DW-1:0];
                    low_reg[k][i] <= {low_reg[k-1][i][QB-2:0], 1'b0};
                    q_reg[k][i]   <= {q_reg[k-1][i][QB-2:0], ge};
                    big_reg[k][i] <= big_reg[k-1][i];
                end
            end
        end
    end

    always_comb begin
        logic [DW-1:0] best, d;
        logic          ehit;
        logic [1:0]    eidx;
        hht_pkg::job_t j;
        j    = job_reg[QB];
        best = DW'(r2);
        ehit = 1'b0;
        eidx = '0;
        for (int i = 0; i < NC; i++) begin
            if (!j.edges[i].interior) begin
                d = j.edges[i].fixed_dist;
            end else if (big_reg[QB][i]) begin
                d = '1;
            end else begin
                d = DW'(q_reg[QB][i]);
            end
            if (d < best) begin
                best = d;
                ehit = 1'b1;
                eidx = 2'(i);
            end
        end
        priority if (j.vertex_hit) begin
            kind_next  = hht_pkg::KIND_VERTEX;
            index_next = j.vertex_idx;
        end else if (ehit) begin
            kind_next  = hht_pkg::KIND_EDGE;
            index_next = eidx;
        end else if (j.body_hit) begin
            kind_next  = hht_pkg::KIND_BODY;
            index_next = '0;
        end else begin
            kind_next  = hht_pkg::KIND_NONE;
            index_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= QB; k++) begin
                dv_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            b1_valid_reg  <= in_valid;
            dv_reg[0]     <= b1_valid_reg;
            for (int k = 1; k <= QB; k++) begin
                dv_reg[k] <= dv_reg[k-1];
            end
            out_valid_reg <= dv_reg[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            kind_reg  <= kind_next;
            index_reg <= index_next;
            hit_reg   <= (kind_next != hht_pkg::KIND_NONE);
            surf_reg  <= (kind_next != hht_pkg::KIND_NONE) ? surface : 16'd0;
        end
    end

endmodule

>>> rtl/quad_handle_hit_test.sv
// Top level of the quad handle hit test: configuration registers and pipeline assembly.
// A point passes 4 front stages, the job queue, and 34 back stages (partial squares,
// their sum, 31 single-bit restoring division steps, output). One point per cycle
// enters unless m_tready stalls the output; the per-edge divider sets the depth.
// Reset is synchronous and active low: corners return to the unit square, the
// radius to 164, the surface identifier to 0, and all pipelines and the queue empty.
module quad_handle_hit_test #(
    parameter int COORD_FRAC_BITS = 14,
    parameter int QUEUE_DEPTH     = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // point_x [15:0], point_y [31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // hit [0], handle_kind [2:1], handle_index [4:3],
                                   // hit_surface [20:5], zero fill [23:21]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam logic [15:0] ONE_COORD =
        (COORD_FRAC_BITS < 16) ? 16'(32'd1 << COORD_FRAC_BITS) : 16'd0;

    logic [hht_pkg::NumC-1:0][31:0] corner_reg;
    logic [14:0]                    radius_reg;
    logic [15:0]                    surface_reg;
    logic [hht_pkg::R2W-1:0]        r2_reg;

    logic           q_push, q_pop, q_full, q_empty;
    hht_pkg::job_t  q_in, q_out;
    logic           o_hit;
    hht_pkg::kind_t o_kind;
    logic [1:0]     o_index;
    logic [15:0]    o_surface;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corner_reg[0] <= 32'd0;
            corner_reg[1] <= {16'd0, ONE_COORD};
            corner_reg[2] <= {ONE_COORD, ONE_COORD};
            corner_reg[3] <= {ONE_COORD, 16'd0};
            radius_reg    <= 15'd164;
            surface_reg   <= 16'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                hht_pkg::REG_CORNER_0: corner_reg[0] <= cfg_wdata;
                hht_pkg::REG_CORNER_1: corner_reg[1] <= cfg_wdata;
                hht_pkg::REG_CORNER_2: corner_reg[2] <= cfg_wdata;
                hht_pkg::REG_CORNER_3: corner_reg[3] <= cfg_wdata;
                hht_pkg::REG_RADIUS:   radius_reg    <= cfg_wdata[14:0];
                hht_pkg::REG_SURFACE:  surface_reg   <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        r2_reg <= radius_reg * radius_reg;
    end

    hht_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_x     (s_tdata[15:0]),
        .in_y     (s_tdata[31:16]),
        .corners  (corner_reg),
        .r2       (r2_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_in)
    );

    hht_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .W     ($bits(hht_pkg::job_t))
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_in),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_out),
        .empty   (q_empty)
    );

    logic back_ready;
    assign q_pop = back_ready && !q_empty;

    hht_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (!q_empty),
        .in_ready    (back_ready),
        .in_job      (q_out),
        .r2          (r2_reg),
        .surface     (surface_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_hit     (o_hit),
        .out_kind    (o_kind),
        .out_index   (o_index),
        .out_surface (o_surface)
    );

    assign m_tdata = {3'd0, o_surface, o_index, o_kind, o_hit};

    a_hit_matches_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (o_hit == (o_kind != hht_pkg::KIND_NONE)))
        else $error("hit flag disagrees with handle kind");

    a_body_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (o_kind == hht_pkg::KIND_BODY || o_kind == hht_pkg::KIND_NONE))
        |-> (o_index == 2'd0))
        else $error("nonzero index on body or miss");

    a_miss_surface_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !o_hit) |-> (o_surface == 16'd0))
        else $error("surface reported on a miss");

    a_queue_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !q_push)
        else $error("push into a full job queue");

endmodule
